[rtl/core/rip_packet_parse_validate_assert.svh]
// Assertion macros for the RIPv2 packet parser
`ifndef RIP_PACKET_PARSE_VALIDATE_ASSERT_SVH
`define RIP_PACKET_PARSE_VALIDATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RPV_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define RPV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define RPV_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RPV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/rpv_pkg.sv]
// Shared types and constants for the RIPv2 packet parser
package rpv_pkg;

    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_LENGTH   = 4'd1,
        ERR_COMMAND  = 4'd2,
        ERR_VERSION  = 4'd3,
        ERR_ZERO     = 4'd4,
        ERR_FAMILY   = 4'd5,
        ERR_TAG      = 4'd6,
        ERR_MASK     = 4'd7,
        ERR_METRIC   = 4'd8,
        ERR_TOO_MANY = 4'd9
    } t_err;

    localparam logic KIND_ROUTE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_beat;

    typedef struct packed {
        logic        result_kind;
        logic [4:0]  entry_index;
        logic [31:0] route_address;
        logic [31:0] route_mask;
        logic [31:0] next_hop;
        logic [31:0] route_metric;
        logic        packet_ok;
        logic [7:0]  rip_command;
        logic [4:0]  entry_total;
        t_err        error_code;
    } t_result;

endpackage

[rtl/core/rip_packet_parse_validate.sv]
// Top level: RIPv2 packet byte parser and validator.
// Bytes pass the input register, parse stage and output register; 1 byte per cycle while i_stall is low.
// The rate is set by the parse stage, which updates the per-packet state once per byte.
// Reset: synchronous active-low i_rst_n clears both stages and the packet state at once.
`include "rip_packet_parse_validate_assert.svh"
module rip_packet_parse_validate #(
    parameter int MAX_ENTRIES = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [4:0]  o_entry_index,
    output logic [31:0] o_route_address,
    output logic [31:0] o_route_mask,
    output logic [31:0] o_next_hop,
    output logic [31:0] o_route_metric,
    output logic        o_packet_ok,
    output logic [7:0]  o_rip_command,
    output logic [4:0]  o_entry_total,
    output logic [3:0]  o_error_code
);

    rpv_pkg::t_beat   beat;
    rpv_pkg::t_result parse_result, out_result;
    logic             beat_valid, out_free, take, has_result;

    assign take = beat_valid && out_free;

    rpv_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .i_take       (take),
        .o_stall      (o_stall),
        .o_beat_valid (beat_valid),
        .o_beat       (beat)
    );

    rpv_parser #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (take),
        .i_beat       (beat),
        .o_has_result (has_result),
        .o_result     (parse_result)
    );

    rpv_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && has_result),
        .i_result (parse_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_result_kind   = out_result.result_kind;
    assign o_entry_index   = out_result.entry_index;
    assign o_route_address = out_result.route_address;
    assign o_route_mask    = out_result.route_mask;
    assign o_next_hop      = out_result.next_hop;
    assign o_route_metric  = out_result.route_metric;
    assign o_packet_ok     = out_result.packet_ok;
    assign o_rip_command   = out_result.rip_command;
    assign o_entry_total   = out_result.entry_total;
    assign o_error_code    = out_result.error_code;

    `RPV_ASSERT_IMPL(a_verdict_ok, i_clk, i_rst_n, o_valid && o_result_kind == rpv_pkg::KIND_VERDICT, o_packet_ok == (o_error_code == rpv_pkg::ERR_NONE))
    `RPV_ASSERT_IMPL(a_route_clean, i_clk, i_rst_n, o_valid && o_result_kind == rpv_pkg::KIND_ROUTE, !o_packet_ok && o_error_code == rpv_pkg::ERR_NONE)
    `RPV_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_stall, beat_valid && o_valid && i_stall)
    `RPV_ASSERT_NEXT(a_take_drains, i_clk, i_rst_n, take && !(i_valid && !o_stall), !beat_valid)

endmodule

[rtl/core/rpv_in_stage.sv]
// Input register stage: holds one byte beat for the parse stage
module rpv_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte_value,
    input  logic           i_last_byte,
    input  logic           i_take,
    output logic           o_stall,
    output logic           o_beat_valid,
    output rpv_pkg::t_beat o_beat
);

    logic           r_valid;
    rpv_pkg::t_beat r_beat;
    logic           n_load;

    assign o_stall      = r_valid && !i_take;
    assign n_load       = i_valid && !o_stall;
    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_beat.byte_value <= i_byte_value;
            r_beat.last_byte  <= i_last_byte;
        end
    end

endmodule

[rtl/core/rpv_parser.sv]
// Parse stage: per-packet state, header and entry checks, result forming
module rpv_parser #(
    parameter int MAX_ENTRIES = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  rpv_pkg::t_beat   i_beat,
    output logic             o_has_result,
    output rpv_pkg::t_result o_result
);

    localparam int ED_W = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W = 12;
    localparam logic [29:0] DIV5_RECIP = 30'd52429;
    localparam logic [7:0] CMD_REQUEST = 8'd1;
    localparam logic [7:0] CMD_RESPONSE = 8'd2;
    localparam logic [7:0] RIP_VERSION = 8'd2;
    localparam logic [15:0] FAMILY_INET = 16'd2;
    localparam logic [15:0] UDP_BYTES = 16'd8;
    localparam logic [15:0] RIP_HDR_TAIL = 16'd12;
    localparam logic [4:0] OFF_FAMILY = 5'd3;
    localparam logic [4:0] OFF_ADDR = 5'd7;
    localparam logic [4:0] OFF_MASK = 5'd11;
    localparam logic [4:0] OFF_HOP = 5'd15;
    localparam logic [4:0] OFF_LAST = 5'd19;
    localparam logic [31:0] METRIC_MAX = 32'd16;

    logic [15:0]       r_pos, n_pos;
    logic [15:0]       r_total, n_total;
    logic [5:0]        r_header, n_header;
    logic [7:0]        r_cmd, n_cmd;
    logic [4:0]        r_off, n_off;
    logic [ED_W-1:0]   r_done, n_done;
    logic [31:0]       r_shift, n_shift;
    rpv_pkg::t_err     r_err, n_err;
    logic [31:0]       r_addr, r_mask, r_hop;
    logic              n_addr_we, n_mask_we, n_hop_we;

    logic [15:0]       tot_now, need, diff, rip, received_lo;
    logic [5:0]        hdr_now;
    logic [29:0]       prod;
    logic [CNT_W-1:0]  count;
    logic [31:0]       word, swapped, inv;
    logic [15:0]       fam;
    logic              have_entry, short_pkt;
    logic [16:0]       received;
    rpv_pkg::t_err     code;

    function automatic rpv_pkg::t_err note(input rpv_pkg::t_err cur,
                                           input rpv_pkg::t_err nxt);
        return (cur == rpv_pkg::ERR_NONE) ? nxt : cur;
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // entries implied by total length: (total - hdr - 12) / 20
    always_comb begin
        hdr_now = (r_pos == 16'd0) ? {i_beat.byte_value[3:0], 2'b00} : r_header;
        if (r_pos == 16'd2) begin
            tot_now = {i_beat.byte_value, r_total[7:0]};
        end else if (r_pos == 16'd3) begin
            tot_now = {r_total[15:8], i_beat.byte_value};
        end else begin
            tot_now = r_total;
        end
        need = 16'(hdr_now) + RIP_HDR_TAIL;
        diff = tot_now - need;
        prod = 30'(diff[15:2]) * DIV5_RECIP;
        count = (tot_now < need) ? '0 : prod[29:18];
    end

    always_comb begin
        n_pos      = r_pos;
        n_total    = tot_now;
        n_header   = hdr_now;
        n_cmd      = r_cmd;
        n_off      = r_off;
        n_done     = r_done;
        n_shift    = r_shift;
        n_err      = r_err;
        n_addr_we  = 1'b0;
        n_mask_we  = 1'b0;
        n_hop_we   = 1'b0;
        have_entry = 1'b0;
        rip        = 16'(r_header) + UDP_BYTES;
        word       = r_shift | (32'(i_beat.byte_value) << {r_off[1:0], 3'b000});
        swapped    = swap32(word);
        inv        = ~swapped;
        fam        = {word[7:0], word[15:8]};

        if (r_pos > 16'd3 && r_pos >= rip) begin
            if (r_pos == rip) begin
                n_cmd = i_beat.byte_value;
                if (i_beat.byte_value != CMD_REQUEST && i_beat.byte_value != CMD_RESPONSE) begin
                    n_err = note(n_err, rpv_pkg::ERR_COMMAND);
                end
            end else if (r_pos == rip + 16'd1) begin
                if (i_beat.byte_value != RIP_VERSION) begin
                    n_err = note(n_err, rpv_pkg::ERR_VERSION);
                end
            end else if (r_pos == rip + 16'd2) begin
                if (i_beat.byte_value != 8'd0) begin
                    n_err = note(n_err, rpv_pkg::ERR_ZERO);
                end
            end else if (r_pos == rip + 16'd3) begin
                if (i_beat.byte_value != 8'd0) begin
                    n_err = note(n_err, rpv_pkg::ERR_ZERO);
                end
                if (32'(count) > 32'(MAX_ENTRIES)) begin
                    n_err = note(n_err, rpv_pkg::ERR_TOO_MANY);
                end
            end else if (32'(r_done) < 32'(count) && 32'(r_done) < 32'(MAX_ENTRIES)) begin
                n_shift = word;
                if (r_off[1:0] == 2'b11) begin
                    n_shift = '0;
                    priority if (r_off == OFF_FAMILY) begin
                        if (!((r_cmd == CMD_REQUEST && fam == 16'd0) ||
                              (r_cmd == CMD_RESPONSE && fam == FAMILY_INET))) begin
                            n_err = note(n_err, rpv_pkg::ERR_FAMILY);
                        end
                        if (word[31:16] != 16'd0) begin
                            n_err = note(n_err, rpv_pkg::ERR_TAG);
                        end
                    end else if (r_off == OFF_ADDR) begin
                        n_addr_we = 1'b1;
                    end else if (r_off == OFF_MASK) begin
                        n_mask_we = 1'b1;
                        if ((inv & (inv + 32'd1)) != 32'd0) begin
                            n_err = note(n_err, rpv_pkg::ERR_MASK);
                        end
                    end else if (r_off == OFF_HOP) begin
                        n_hop_we = 1'b1;
                    end else begin
                        if (swapped < 32'd1 || swapped > METRIC_MAX) begin
                            n_err = note(n_err, rpv_pkg::ERR_METRIC);
                        end
                        n_done     = r_done + ED_W'(1);
                        have_entry = (n_err == rpv_pkg::ERR_NONE);
                    end
                end
                n_off = (r_off >= OFF_LAST) ? 5'd0 : r_off + 5'd1;
            end
        end

        received    = {1'b0, r_pos} + 17'd1;
        received_lo = rip + 16'd3;
        short_pkt   = (r_pos < received_lo) || ({1'b0, n_total} > received);
        code        = short_pkt ? rpv_pkg::ERR_LENGTH : n_err;

        o_result.result_kind   = i_beat.last_byte ? rpv_pkg::KIND_VERDICT
                                                  : rpv_pkg::KIND_ROUTE;
        o_result.entry_index   = i_beat.last_byte ? 5'(n_done) : 5'(r_done);
        o_result.route_address = have_entry ? r_addr : '0;
        o_result.route_mask    = have_entry ? r_mask : '0;
        o_result.next_hop      = have_entry ? r_hop : '0;
        o_result.route_metric  = have_entry ? word : '0;
        o_result.packet_ok     = i_beat.last_byte && (code == rpv_pkg::ERR_NONE);
        o_result.rip_command   = n_cmd;
        o_result.entry_total   = (count > CNT_W'(31)) ? 5'd31 : count[4:0];
        o_result.error_code    = i_beat.last_byte ? code : rpv_pkg::ERR_NONE;
        o_has_result           = i_beat.last_byte || have_entry;

        if (i_beat.last_byte) begin
            n_pos    = '0;
            n_total  = '0;
            n_header = '0;
            n_cmd    = '0;
            n_off    = '0;
            n_done   = '0;
            n_shift  = '0;
            n_err    = rpv_pkg::ERR_NONE;
        end else if (r_pos != 16'hffff) begin
            n_pos = r_pos + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_total  <= '0;
            r_header <= '0;
            r_cmd    <= '0;
            r_off    <= '0;
            r_done   <= '0;
            r_shift  <= '0;
            r_err    <= rpv_pkg::ERR_NONE;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_total  <= n_total;
            r_header <= n_header;
            r_cmd    <= n_cmd;
            r_off    <= n_off;
            r_done   <= n_done;
            r_shift  <= n_shift;
            r_err    <= n_err;
        end
    end

    // held words are always rewritten within an entry before use
    always_ff @(posedge i_clk) begin
        if (i_fire && n_addr_we) begin
            r_addr <= word;
        end
        if (i_fire && n_mask_we) begin
            r_mask <= word;
        end
        if (i_fire && n_hop_we) begin
            r_hop <= word;
        end
    end

endmodule

[rtl/core/rpv_out_stage.sv]
// Output register stage: holds one result beat until taken
module rpv_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rpv_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output rpv_pkg::t_result o_result
);

    logic             r_valid;
    rpv_pkg::t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule
